[hdl/gcct_pkg.sv]
// Shared types, constants and CORDIC angle table for the great-circle collinearity test.
`timescale 1ns / 1ps
package gcct_pkg;

  localparam int TOL_W = 40;
  localparam int TP_W  = 62;
  localparam int Q_W   = 32;   // Q1.30 components, signed
  localparam int Z_W   = 64;   // Q61 radians, signed
  localparam int MAX_ITER = 40;

  localparam logic [TOL_W-1:0] TOL_RESET = 40'd115292150;
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic signed [Z_W-1:0] GAIN_Q61 = 64'sd1400229935014726477;
  localparam logic signed [Q_W-1:0] Q30_ONE = 32'sd1073741824;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDEF   = 2'd1,
    ST_BAD_LAT = 2'd2
  } status_t;

  // Unit vector of one point, Q1.30 components.
  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
  } vec_t;

  // Sideband that travels beside the lanes.
  typedef struct packed {
    logic    valid;
    status_t status;
  } side_t;

  // atan(2^-i) in Q61, alternating series evaluated at elaboration.
  function automatic logic signed [Z_W-1:0] atan_q61(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int k;
    sum = '0;
    if (i == 0) return signed'(PI_Q62 >> 3);
    for (k = 0; k < 32; k++) begin
      if (i * (2 * k + 1) <= 62) begin
        term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return signed'(sum >> 1);
  endfunction

endpackage

[hdl/gcct_cordic.sv]
// Pipelined rotation CORDIC: binary angle in, Q1.30 cosine and sine out.
`timescale 1ns / 1ps
module gcct_cordic import gcct_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_ITERATIONS = 30
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [Q_W-1:0]        cos_q,
  output logic signed [Q_W-1:0]        sin_q
);
  localparam int N = CORDIC_ITERATIONS;
  localparam int MW = ANGLE_BITS + 64;

  // stage 0: magnitude times pi, split into two 32-bit-ish products
  logic [ANGLE_BITS-1:0] mag;
  logic                  neg_r;
  logic [MW-1:0]         plo_r, phi_r;
  logic [MW-1:0]         prod;
  logic [Z_W-1:0]        rad_u;
  logic signed [Z_W-1:0] rad;

  assign mag = angle[ANGLE_BITS-1] ? ANGLE_BITS'(-angle) : angle;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= angle[ANGLE_BITS-1];
      plo_r <= MW'(mag) * MW'(PI_Q62[31:0]);
      phi_r <= MW'(mag) * MW'(PI_Q62[63:32]);
    end
  end

  assign prod  = plo_r + (phi_r << 32);
  assign rad_u = prod[ANGLE_BITS +: Z_W];
  assign rad   = neg_r ? Z_W'(-signed'(rad_u)) : signed'(rad_u);

  logic signed [Z_W-1:0] x_r [N+1];
  logic signed [Z_W-1:0] y_r [N+1];
  logic signed [Z_W-1:0] z_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q61;
      y_r[0] <= '0;
      z_r[0] <= rad;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [Z_W-1:0] T = atan_q61(i);
    localparam int SH = (i < 63) ? i : 63;
    logic signed [Z_W-1:0] dx, dy;
    assign dx = y_r[i] >>> SH;
    assign dy = x_r[i] >>> SH;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][Z_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - T;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + T;
        end
      end
    end
  end

  function automatic logic signed [Q_W-1:0] to_q30(input logic signed [Z_W-1:0] v);
    logic signed [Z_W-1:0] r;
    r = (v + (64'sd1 <<< 30)) >>> 31;
    if (r > 64'sd1073741824) return Q30_ONE;
    if (r < -64'sd1073741824) return -Q30_ONE;
    return Q_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= to_q30(x_r[N]);
      sin_q <= to_q30(y_r[N]);
    end
  end
endmodule

[hdl/gcct_lane.sv]
// One point lane: range fold, latitude and longitude CORDICs, unit vector.
`timescale 1ns / 1ps
module gcct_lane import gcct_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_ITERATIONS = 30
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] lat,
  input  logic signed [ANGLE_BITS-1:0] lon,
  output vec_t                         vec
);
  localparam int DLY = CORDIC_ITERATIONS + 3;
  localparam logic signed [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);
  localparam logic signed [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) <<< (ANGLE_BITS - 1);

  logic signed [ANGLE_BITS-1:0] lon_f;
  logic                         flip;

  always_comb begin
    flip  = 1'b0;
    lon_f = lon;
    if (lon > QUARTER) begin
      lon_f = lon - HALF;
      flip  = 1'b1;
    end else if (lon < -QUARTER) begin
      lon_f = lon + HALF;
      flip  = 1'b1;
    end
  end

  logic signed [Q_W-1:0] cl, sl, co, so;
  logic flip_d [DLY+1];

  gcct_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_lat (
    .clk(clk), .en(en), .angle(lat), .cos_q(cl), .sin_q(sl));
  gcct_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_lon (
    .clk(clk), .en(en), .angle(lon_f), .cos_q(co), .sin_q(so));

  assign flip_d[0] = flip;
  for (genvar i = 0; i < DLY; i++) begin : g_flip
    always_ff @(posedge clk) if (en) flip_d[i+1] <= flip_d[i];
  end

  logic signed [Q_W-1:0] cof, sof, sl_r;
  logic signed [63:0]    px_r, py_r;
  assign cof = flip_d[DLY] ? -co : co;
  assign sof = flip_d[DLY] ? -so : so;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 64'(cl) * 64'(cof);
      py_r <= 64'(cl) * 64'(sof);
      sl_r <= sl;
      vec.x <= Q_W'((px_r + (64'sd1 <<< 29)) >>> 30);
      vec.y <= Q_W'((py_r + (64'sd1 <<< 29)) >>> 30);
      vec.z <= sl_r;
    end
  end
endmodule

[hdl/gcct_merge.sv]
// Merge stage: cross product, dot product, rounding, saturation and compare.
`timescale 1ns / 1ps
module gcct_merge import gcct_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  vec_t              va,
  input  vec_t              vb,
  input  vec_t              vc,
  input  logic [TOL_W-1:0]  tol,
  output logic signed [TP_W-1:0] tp,
  output logic              coll
);
  // stage 1: six products of the cross product
  logic signed [63:0] m_r [6];
  vec_t c1_r, c2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= 64'(va.y) * 64'(vb.z);
      m_r[1] <= 64'(va.z) * 64'(vb.y);
      m_r[2] <= 64'(va.z) * 64'(vb.x);
      m_r[3] <= 64'(va.x) * 64'(vb.z);
      m_r[4] <= 64'(va.x) * 64'(vb.y);
      m_r[5] <= 64'(va.y) * 64'(vb.x);
      c1_r   <= vc;
    end
  end

  // stage 2: normal vector
  logic signed [63:0] n_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= m_r[0] - m_r[1];
      n_r[1] <= m_r[2] - m_r[3];
      n_r[2] <= m_r[4] - m_r[5];
      c2_r   <= c1_r;
    end
  end

  // stage 3/4: 64x32 products split in halves
  logic signed [63:0] lo_r [3];
  logic signed [63:0] hi_r [3];
  logic signed [Q_W-1:0] cc [3];
  assign cc[0] = c2_r.x;
  assign cc[1] = c2_r.y;
  assign cc[2] = c2_r.z;
  for (genvar k = 0; k < 3; k++) begin : g_dot
    always_ff @(posedge clk) begin
      if (en) begin
        lo_r[k] <= signed'({32'd0, n_r[k][31:0]}) * 64'(cc[k]);
        hi_r[k] <= 64'(signed'(n_r[k][63:32])) * 64'(cc[k]);
      end
    end
  end

  logic signed [127:0] p_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        p_r[k] <= 128'(lo_r[k]) + (128'(hi_r[k]) <<< 32);
    end
  end

  logic signed [127:0] sum_r;
  always_ff @(posedge clk) if (en) sum_r <= p_r[0] + p_r[1] + p_r[2] + (128'sd1 <<< 29);

  logic signed [63:0] t;
  logic signed [127:0] sh;
  localparam logic signed [127:0] TMAX = 128'sd2305843009213693951;
  assign sh = sum_r >>> 30;
  // (hi<<34|lo>>30) in the model is a 64-bit wrap of the shifted sum
  always_comb begin
    t = sh[63:0];
    if (t > 64'(TMAX)) t = 64'(TMAX);
    if (t < -64'(TMAX) - 64'sd1) t = -64'(TMAX) - 64'sd1;
  end

  logic [63:0] mag;
  assign mag = t[63] ? 64'(-t) : 64'(t);

  always_ff @(posedge clk) begin
    if (en) begin
      tp   <= t[TP_W-1:0];
      coll <= mag < {24'd0, tol};
    end
  end
endmodule

[hdl/great_circle_collinearity_test.sv]
// Top level of the great-circle collinearity test: lanes, merge and output skid.
`timescale 1ns / 1ps
//  channel | dir | tdata fields (low bit up)                                 | tuser
//  in_     | in  | a_lat, a_lon, a_def, b_lat, b_lon, b_def, c_lat, c_lon, c_def | -
//  out_    | out | status(2), triple_product(62)                             | collinear
//  cfg_    | in  | collinear_tolerance(40), write on cfg_wr_en               | -
// One item per cycle sustained while the output keeps draining; out_tvalid rises once an
// item has passed angle scaling and CORDIC (CORDIC_ITERATIONS + 3 stages), each lane's
// two more, the merge's six and the output queue's one.
// The whole pipeline advances only when its last stage can move; a two-entry queue at
// the output absorbs results, so in_tready drops only while the queue is full, the last
// stage holds an item and out_tready is low, or while rst_n is low.
// rst_n (synchronous) clears valid bits, empties the output queue and restores the tolerance register.
module great_circle_collinearity_test import gcct_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_ITERATIONS = 30
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [199:0]  in_tdata,   // a_lat, a_lon, a_def, b_lat, b_lon, b_def, c_lat, c_lon, c_def
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // status, triple_product
  output logic          out_tuser,  // collinear
  input  logic          cfg_wr_en,
  input  logic [39:0]   cfg_wr_data // collinear_tolerance
);
  localparam int LAT = CORDIC_ITERATIONS + 11;
  localparam int AW = (ANGLE_BITS < 32) ? ANGLE_BITS : 32;

  logic [TOL_W-1:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_RESET;
    else if (cfg_wr_en) tol_r <= cfg_wr_data;
  end

  // output skid: two entries
  logic [1:0]  cnt_r;
  logic [64:0] q_r [2];
  logic        en;
  side_t       sd [LAT+1];
  logic        ready_pipe;

  // advance while the last stage has room
  assign en = !sd[LAT].valid || (cnt_r < 2'd2) || (out_tready && out_tvalid);
  assign ready_pipe = en;
  assign in_tready = ready_pipe && rst_n;

  function automatic logic signed [ANGLE_BITS-1:0] ang(input logic [31:0] raw);
    logic signed [AW-1:0] v;
    v = signed'(raw[AW-1:0]);
    return ANGLE_BITS'(v);
  endfunction

  logic signed [ANGLE_BITS-1:0] lat [3];
  logic signed [ANGLE_BITS-1:0] lon [3];
  logic def [3];
  vec_t v [3];
  localparam logic signed [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);

  logic bad, undef;
  always_comb begin
    bad = 1'b0;
    undef = 1'b0;
    for (int p = 0; p < 3; p++) begin
      lat[p] = ang(in_tdata[p*65 +: 32]);
      lon[p] = ang(in_tdata[p*65+32 +: 32]);
      def[p] = in_tdata[p*65+64];
      if (!def[p]) undef = 1'b1;
      else if (lat[p] > QUARTER || lat[p] < -QUARTER) bad = 1'b1;
    end
  end

  for (genvar p = 0; p < 3; p++) begin : g_lane
    gcct_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_lane (
      .clk(clk), .en(en), .lat(lat[p]), .lon(lon[p]), .vec(v[p]));
  end

  logic signed [TP_W-1:0] tp;
  logic coll;
  gcct_merge u_merge (
    .clk(clk), .en(en), .va(v[0]), .vb(v[1]), .vc(v[2]), .tol(tol_r),
    .tp(tp), .coll(coll));

  assign sd[0].valid  = in_tvalid && in_tready;
  assign sd[0].status = bad ? ST_BAD_LAT : (undef ? ST_UNDEF : ST_OK);
  for (genvar i = 0; i < LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) sd[i+1] <= '{valid: 1'b0, status: ST_OK};
      else if (en) sd[i+1] <= sd[i];
    end
  end

  logic [64:0] res;
  logic push, pop;
  assign res = (sd[LAT].status == ST_OK) ? {coll, tp, ST_OK} :
               {1'b0, {TP_W{1'b0}}, sd[LAT].status};
  assign pop  = out_tvalid && out_tready;
  assign push = sd[LAT].valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    case ({push, pop})
      2'b10: q_r[cnt_r[0]] <= res;
      2'b01: q_r[0] <= q_r[1];
      2'b11: begin
        if (cnt_r == 2'd1) begin
          q_r[0] <= res;
        end else begin
          q_r[0] <= q_r[1];
          q_r[1] <= res;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q_r[0][63:0];
  assign out_tuser  = q_r[0][64];

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("skid overflow");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> (cnt_r < 2'd2) || pop)
    else $error("push into full skid");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[1:0] == ST_OK)
    else $error("collinear flagged on error result");
endmodule
